>>> design/dfu_pkg.sv
// Shared types and constants for the delimited frame unstuffer.
`default_nettype none
package dfu_pkg;

	localparam int DEF_COUNT_BITS = 10;
	localparam int LEN_BITS       = 10;
	localparam int BYTE_BITS      = 8;
	localparam int CFG_IDX_BITS   = 2;

	localparam logic [BYTE_BITS-1:0] RST_DELIM     = 8'd18;
	localparam logic [BYTE_BITS-1:0] RST_ESC       = 8'd219;
	localparam logic [BYTE_BITS-1:0] RST_ESC_DELIM = 8'd222;
	localparam logic [BYTE_BITS-1:0] RST_ESC_ESC   = 8'd221;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DELIM     = 2'd0,
		REG_ESC       = 2'd1,
		REG_ESC_DELIM = 2'd2,
		REG_ESC_ESC   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_OPENED = 2'd1,
		PH_FRAME  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] delim;
		logic [BYTE_BITS-1:0] esc;
		logic [BYTE_BITS-1:0] esc_delim;
		logic [BYTE_BITS-1:0] esc_esc;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] out_byte;
		logic                 byte_valid;
		logic                 bad_escape;
		logic                 frame_end;
		logic [LEN_BITS-1:0]  frame_length;
	} result_t;

endpackage
`default_nettype wire

>>> design/delimited_frame_unstuffer_top.sv
// Top level of the delimited frame unstuffer.
// Feed one received serial byte per input transaction on in_valid/in_ready/rx_byte.
// Bytes outside a frame are dropped until the delimiter opens one; a repeated
// delimiter right after the opener is taken as the opener. Inside a frame,
// escape sequences are decoded and each payload byte leaves as one output
// transaction; the closing delimiter gives a transaction with frame_end and the
// saturated byte count in frame_length. An escape followed by an unknown code or
// by the closing delimiter gives out_byte 0 with bad_escape set.
// An accepted byte is decoded from the input stage into the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single decode step between the input stage and the output register.
// When out_ready is low the output register holds its transaction, the input
// stage holds the next byte, and in_ready drops only once both are occupied.
// Bytes that give no result pass the input stage even while the output stalls.
// Reset clears framing state and both stages and loads the default delimiter
// and escape values. The cfg channel is always ready; write it only while idle.
`default_nettype none
module delimited_frame_unstuffer_top
	import dfu_pkg::*;
#(
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [BYTE_BITS-1:0]    cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [BYTE_BITS-1:0]    rx_byte,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [BYTE_BITS-1:0]         out_byte,
	output logic                         byte_valid,
	output logic                         bad_escape,
	output logic                         frame_end,
	output logic [LEN_BITS-1:0]          frame_length
);

	cfg_t    cfg;
	result_t res;
	result_t out_res;
	logic    res_push;
	logic    res_room;

	dfu_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dfu_decode #(
		.COUNT_BITS (COUNT_BITS)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.cfg      (cfg),
		.res_room (res_room),
		.res_push (res_push),
		.res      (res)
	);

	dfu_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res       (res),
		.res_room  (res_room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign out_byte     = out_res.out_byte;
	assign byte_valid   = out_res.byte_valid;
	assign bad_escape   = out_res.bad_escape;
	assign frame_end    = out_res.frame_end;
	assign frame_length = out_res.frame_length;

endmodule
`default_nettype wire

>>> design/dfu_cfg_regs.sv
// Configuration register file of the delimited frame unstuffer.
`default_nettype none
module dfu_cfg_regs
	import dfu_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [BYTE_BITS-1:0]    cfg_data,
	output cfg_t                         cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim     <= RST_DELIM;
			cfg_q.esc       <= RST_ESC;
			cfg_q.esc_delim <= RST_ESC_DELIM;
			cfg_q.esc_esc   <= RST_ESC_ESC;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DELIM:     cfg_q.delim     <= cfg_data;
				REG_ESC:       cfg_q.esc       <= cfg_data;
				REG_ESC_DELIM: cfg_q.esc_delim <= cfg_data;
				REG_ESC_ESC:   cfg_q.esc_esc   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/dfu_decode.sv
// Input register, framing state and unescape decision of the unstuffer.
`default_nettype none
module dfu_decode
	import dfu_pkg::*;
#(
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [BYTE_BITS-1:0] rx_byte,
	input  wire cfg_t                 cfg,
	input  wire logic                 res_room,
	output logic                      res_push,
	output result_t                   res
);

	localparam int WIDE = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [WIDE-1:0]       LEN_MAX = WIDE'({LEN_BITS{1'b1}});

	logic                  valid_s1;
	logic [BYTE_BITS-1:0]  rx_s1;
	phase_t                phase_q, phase_d;
	logic                  esc_q, esc_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;

	logic                  has_res;
	logic                  advance;
	logic                  fire;
	logic                  is_delim;
	logic                  in_frame;
	logic [COUNT_BITS-1:0] cnt_bump;
	logic [COUNT_BITS-1:0] cnt_len;
	logic [WIDE-1:0]       cnt_wide;
	result_t               res_c;

	assign advance  = !has_res || res_room;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign res_push = fire && has_res;
	assign res      = res_c;

	assign is_delim = (rx_s1 == cfg.delim);
	assign in_frame = (phase_q == PH_OPENED) || (phase_q == PH_FRAME);
	assign cnt_bump = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + COUNT_BITS'(1);

	always_comb begin
		phase_d          = phase_q;
		esc_d            = esc_q;
		cnt_d            = cnt_q;
		has_res          = 1'b0;
		cnt_len          = cnt_bump;
		res_c.out_byte   = '0;
		res_c.byte_valid = 1'b0;
		res_c.bad_escape = 1'b0;
		res_c.frame_end  = 1'b0;
		priority if (!in_frame) begin
			if (is_delim) begin
				phase_d = PH_OPENED;
				esc_d   = 1'b0;
				cnt_d   = '0;
			end else begin
				phase_d = phase_q;
			end
		end else if (phase_q == PH_OPENED && is_delim) begin
			phase_d = PH_FRAME;
		end else if (is_delim) begin
			has_res          = 1'b1;
			res_c.byte_valid = esc_q;
			res_c.bad_escape = esc_q;
			res_c.frame_end  = 1'b1;
			cnt_len          = esc_q ? cnt_bump : cnt_q;
			phase_d          = PH_IDLE;
			esc_d            = 1'b0;
			cnt_d            = '0;
		end else if (esc_q) begin
			has_res          = 1'b1;
			res_c.byte_valid = 1'b1;
			phase_d          = PH_FRAME;
			esc_d            = 1'b0;
			cnt_d            = cnt_bump;
			priority if (rx_s1 == cfg.esc_delim) begin
				res_c.out_byte = cfg.delim;
			end else if (rx_s1 == cfg.esc_esc) begin
				res_c.out_byte = cfg.esc;
			end else begin
				res_c.bad_escape = 1'b1;
			end
		end else if (rx_s1 == cfg.esc) begin
			phase_d = PH_FRAME;
			esc_d   = 1'b1;
		end else begin
			has_res          = 1'b1;
			res_c.out_byte   = rx_s1;
			res_c.byte_valid = 1'b1;
			phase_d          = PH_FRAME;
			cnt_d            = cnt_bump;
		end
		if (!valid_s1) begin
			has_res = 1'b0;
		end
		cnt_wide           = WIDE'(cnt_len);
		res_c.frame_length = (cnt_wide > LEN_MAX) ? LEN_MAX[LEN_BITS-1:0]
		                                          : cnt_wide[LEN_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			esc_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
			cnt_q   <= cnt_d;
		end
	end

	a_esc_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> (phase_q == PH_FRAME))
		else $error("escape pending outside a frame");

	a_idle_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE || phase_q == PH_OPENED) |-> (cnt_q == '0))
		else $error("byte count not clear before frame data");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(rx_s1)))
		else $error("stalled input stage lost its byte");

endmodule
`default_nettype wire

>>> design/dfu_out_reg.sv
// Output result register of the delimited frame unstuffer.
`default_nettype none
module dfu_out_reg
	import dfu_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_push,
	input  wire result_t res,
	output logic         res_room,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_res
);

	logic    valid_q;
	result_t res_q;

	assign res_room  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

>>> verif/delimited_frame_unstuffer_tb.sv
// Self-checking testbench for the delimited frame unstuffer: directed frames, then random frames.
`timescale 1ns / 1ps
module testbench;
	import dfu_pkg::*;

	localparam int COUNT_BITS = DEF_COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam int LEN_MAX = (1 << LEN_BITS) - 1;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 100;

	typedef struct packed {
		logic [BYTE_BITS-1:0] rx;
		logic                 typed;
		logic                 has_res;
		result_t              res;
	} dir_row_t;

	localparam dir_row_t DIRECTED [26] = '{
		{8'h00, 1'b1, 1'b0, 21'd0},
		{8'hFF, 1'b1, 1'b0, 21'd0},
		{8'hDB, 1'b1, 1'b0, 21'd0},
		{8'h12, 1'b1, 1'b0, 21'd0},
		{8'h12, 1'b1, 1'b0, 21'd0},
		{8'h00, 1'b1, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 10'd1}},
		{8'hFF, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b0, 1'b0, 10'd2}},
		{8'hDB, 1'b0, 1'b0, 21'd0},
		{8'hDE, 1'b0, 1'b0, 21'd0},
		{8'hDB, 1'b0, 1'b0, 21'd0},
		{8'hDD, 1'b0, 1'b0, 21'd0},
		{8'hDB, 1'b0, 1'b0, 21'd0},
		{8'h55, 1'b1, 1'b1, {8'h00, 1'b1, 1'b1, 1'b0, 10'd5}},
		{8'h12, 1'b1, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 10'd5}},
		{8'h12, 1'b1, 1'b0, 21'd0},
		{8'h12, 1'b1, 1'b0, 21'd0},
		{8'h12, 1'b1, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 10'd0}},
		{8'h12, 1'b0, 1'b0, 21'd0},
		{8'hA5, 1'b0, 1'b0, 21'd0},
		{8'hDB, 1'b0, 1'b0, 21'd0},
		{8'h12, 1'b1, 1'b1, {8'h00, 1'b1, 1'b1, 1'b1, 10'd2}},
		{8'h7E, 1'b1, 1'b0, 21'd0},
		{8'h12, 1'b0, 1'b0, 21'd0},
		{8'hDB, 1'b0, 1'b0, 21'd0},
		{8'hDB, 1'b1, 1'b1, {8'h00, 1'b1, 1'b1, 1'b0, 10'd1}},
		{8'h12, 1'b1, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 10'd1}}
	};

	localparam cfg_t CFG_SETS [PHASES] = '{
		{8'h00, 8'hFF, 8'h01, 8'hFE},
		{8'hFF, 8'h00, 8'hFF, 8'h00},
		{8'h00, 8'h00, 8'h00, 8'h00},
		{RST_DELIM, RST_ESC, RST_ESC_DELIM, RST_ESC_ESC},
		{8'h7E, 8'h7D, 8'h5E, 8'h5D},
		{8'h55, 8'h55, 8'h55, 8'hAA}
	};
	localparam int IDLE_IN   [PHASES] = '{0, 45, 0, 13, 45, 0};
	localparam int STALL_OUT [PHASES] = '{0, 0, 45, 13, 0, 45};

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [BYTE_BITS-1:0]    cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [BYTE_BITS-1:0]    rx_byte;
	logic                    out_valid;
	logic                    out_ready;
	logic [BYTE_BITS-1:0]    out_byte;
	logic                    byte_valid;
	logic                    bad_escape;
	logic                    frame_end;
	logic [LEN_BITS-1:0]     frame_length;

	cfg_t                  cur_regs;
	phase_t                fr_phase;
	logic                  esc_pend;
	logic [COUNT_BITS-1:0] dec_count;
	result_t               pending_results [$];

	int idle_in_pct = 0;
	int stall_out_pct = 0;
	int errors = 0;
	int quiet = 0;
	int n_in_bytes = 0;
	int framed_items = 0;
	int n_results = 0;
	int n_ends = 0;
	int n_bad = 0;

	delimited_frame_unstuffer_top #(
		.COUNT_BITS(COUNT_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.bad_escape(bad_escape),
		.frame_end(frame_end),
		.frame_length(frame_length)
	);

	always #5 clk = ~clk;

	function automatic logic [LEN_BITS-1:0] sat_len(input logic [COUNT_BITS-1:0] c);
		return (32'(c) > LEN_MAX) ? LEN_BITS'(LEN_MAX) : LEN_BITS'(c);
	endfunction

	function automatic bit decode_byte(input logic [BYTE_BITS-1:0] rx, output result_t r);
		logic dangling;
		r = '0;
		if (fr_phase != PH_OPENED && fr_phase != PH_FRAME) begin
			if (rx == cur_regs.delim) begin
				fr_phase = PH_OPENED;
				esc_pend = 1'b0;
				dec_count = '0;
			end
			return 1'b0;
		end
		framed_items++;
		if (fr_phase == PH_OPENED && rx == cur_regs.delim) begin
			fr_phase = PH_FRAME;
			return 1'b0;
		end
		fr_phase = PH_FRAME;
		if (rx == cur_regs.delim) begin
			dangling = esc_pend;
			if (dangling && dec_count != COUNT_MAX) dec_count++;
			r.byte_valid = dangling;
			r.bad_escape = dangling;
			r.frame_end = 1'b1;
			r.frame_length = sat_len(dec_count);
			fr_phase = PH_IDLE;
			esc_pend = 1'b0;
			dec_count = '0;
			return 1'b1;
		end
		if (esc_pend) begin
			esc_pend = 1'b0;
			if (dec_count != COUNT_MAX) dec_count++;
			r.byte_valid = 1'b1;
			if (rx == cur_regs.esc_delim) r.out_byte = cur_regs.delim;
			else if (rx == cur_regs.esc_esc) r.out_byte = cur_regs.esc;
			else r.bad_escape = 1'b1;
			r.frame_length = sat_len(dec_count);
			return 1'b1;
		end
		if (rx == cur_regs.esc) begin
			esc_pend = 1'b1;
			return 1'b0;
		end
		if (dec_count != COUNT_MAX) dec_count++;
		r.out_byte = rx;
		r.byte_valid = 1'b1;
		r.frame_length = sat_len(dec_count);
		return 1'b1;
	endfunction

	function automatic logic [BYTE_BITS-1:0] pick_byte();
		case ($urandom_range(11))
			0: return cur_regs.delim;
			1: return cur_regs.esc;
			2: return cur_regs.esc_delim;
			3: return cur_regs.esc_esc;
			4: return 8'h00;
			5: return 8'hFF;
			default: return BYTE_BITS'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_byte(input logic [BYTE_BITS-1:0] b, input bit typed = 1'b0,
		input bit typed_has = 1'b0, input result_t typed_res = '0);
		result_t r;
		bit has;
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_in_bytes++;
		has = decode_byte(b, r);
		if (typed) begin
			has = typed_has;
			r = typed_res;
		end
		if (has) pending_results.push_back(r);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [BYTE_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_DELIM:     cur_regs.delim = v;
			REG_ESC:       cur_regs.esc = v;
			REG_ESC_DELIM: cur_regs.esc_delim = v;
			REG_ESC_ESC:   cur_regs.esc_esc = v;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_out_pct);
	end

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {out_byte, byte_valid, bad_escape, frame_end, frame_length};
			n_results++;
			if (frame_end) n_ends++;
			if (bad_escape) n_bad++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result byte=%02h valid=%b bad=%b end=%b len=%0d",
						$realtime, got.out_byte, got.byte_valid, got.bad_escape,
						got.frame_end, got.frame_length);
			end else begin
				want = pending_results.pop_front();
				if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
					got.bad_escape !== want.bad_escape || got.frame_end !== want.frame_end ||
					got.frame_length !== want.frame_length) begin
					errors++;
					if (errors <= 10)
						$display("%0t: mismatch exp byte=%02h valid=%b bad=%b end=%b len=%0d, %s%02h valid=%b bad=%b end=%b len=%0d",
							$realtime, want.out_byte, want.byte_valid, want.bad_escape,
							want.frame_end, want.frame_length, "got byte=",
							got.out_byte, got.byte_valid, got.bad_escape,
							got.frame_end, got.frame_length);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
				$display("** delimited_frame_unstuffer_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		cfg_t setting;
		int phase_goal;
		int n;
		int r;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DELIM;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		out_ready = 1'b1;
		cur_regs = {RST_DELIM, RST_ESC, RST_ESC_DELIM, RST_ESC_ESC};
		fr_phase = PH_IDLE;
		esc_pend = 1'b0;
		dec_count = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].has_res, DIRECTED[i].res);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			setting = (p == 2) ? cfg_t'($urandom) : CFG_SETS[p];
			write_reg(REG_DELIM, setting.delim);
			write_reg(REG_ESC, setting.esc);
			write_reg(REG_ESC_DELIM, setting.esc_delim);
			write_reg(REG_ESC_ESC, setting.esc_esc);
			cfg_valid <= 1'b0;
			idle_in_pct = IDLE_IN[p];
			stall_out_pct = STALL_OUT[p];

			phase_goal = framed_items + ITEMS_PER_PHASE;
			while (framed_items < phase_goal) begin
				if ($urandom_range(9) == 0) begin
					repeat ($urandom_range(1, 4)) send_byte(pick_byte());
				end else begin
					repeat ($urandom_range(0, 2)) send_byte(pick_byte());
					send_byte(cur_regs.delim);
					if ($urandom_range(3) == 0) send_byte(cur_regs.delim);
					n = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
					repeat (n) begin
						r = $urandom_range(99);
						if (r < 60) begin
							send_byte(pick_byte());
						end else begin
							send_byte(cur_regs.esc);
							if (r < 75) send_byte(cur_regs.esc_delim);
							else if (r < 88) send_byte(cur_regs.esc_esc);
							else send_byte(pick_byte());
						end
					end
					// close cleanly, close on a dangling escape, or leave open
					r = $urandom_range(19);
					if (r == 0) send_byte(cur_regs.esc);
					if (r != 1) send_byte(cur_regs.delim);
				end
			end
			drain();
		end

		repeat (8) @(posedge clk);
		$display("Sent %0d bytes (%0d inside frames) over reset values and %0d register sets;",
			n_in_bytes, framed_items, PHASES);
		$display("received %0d results, %0d frame ends and %0d bad escapes, %0d mismatches.",
			n_results, n_ends, n_bad, errors);
		if (pending_results.size() != 0)
			$display("%0d expected results never arrived", pending_results.size());
		if (errors == 0 && pending_results.size() == 0) begin
			$display("** delimited_frame_unstuffer_top: PASSED **");
		end else begin
			$display("** delimited_frame_unstuffer_top: FAILED **");
		end
		$finish;
	end

endmodule

>>> files.f
design/dfu_pkg.sv
design/dfu_cfg_regs.sv
design/dfu_decode.sv
design/dfu_out_reg.sv
design/delimited_frame_unstuffer_top.sv
verif/delimited_frame_unstuffer_tb.sv
